// ===== src/kmp_pkg.sv =====
// kmp_pkg: shared sizes, action codes, sequencer states and payload structs
// for the kmp stream matcher; used by kmp_stream_matcher, no dependencies
package kmp_pkg;

    localparam int MAX_PATTERN   = 64;
    localparam int POSITION_BITS = 32;
    localparam int LEN_W         = $clog2(MAX_PATTERN + 1);
    localparam int ADDR_W        = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int SYM_W         = 8;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_TEXT   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WALK,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [SYM_W-1:0] symbol;
    } item_t;

    typedef struct packed {
        logic                     match;
        logic [POSITION_BITS-1:0] start_position;
        logic [LEN_W-1:0]         matched_length;
    } result_t;

endpackage

// ===== src/kmp_ram.sv =====
// kmp_ram: generic simple dual-port ram, one write port and one read port
// with registered read data; no dependencies
module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/kmp_stream_matcher.sv =====
// kmp_stream_matcher: knuth-morris-pratt matcher over a byte stream, pattern
// and prefix table in two kmp_ram instances; depends on kmp_pkg and kmp_ram
//
//   channel   signals                          payload
//   item      item_valid / item_stall / item    action, symbol
//   result    result_valid / result_stall /     match, start_position,
//             result                            matched_length
//
// clear ends in idle; a text byte steps through walk, one failure link per
// step; an append enters walk at once on an empty pattern, else passes
// through load first. each link step is one read of the prefix-table ram
// one item is in work at a time; the result register lets the next item in
// while a result waits, but a text byte waits to finish while it is stalled
// after reset the pattern is empty; the rams need no clearing pass
module kmp_stream_matcher (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  kmp_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output kmp_pkg::result_t result
);
    import kmp_pkg::*;

    state_t                   state_reg, state_next;
    logic [LEN_W-1:0]         k_reg, k_next;
    logic [SYM_W-1:0]         sym_reg, sym_next;
    logic                     text_reg, text_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [LEN_W-1:0]         match_len_reg, match_len_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     out_valid_reg, out_valid_next;
    result_t                  out_reg, out_next;

    logic [LEN_W-1:0]  rd_idx;
    logic [LEN_W-1:0]  pref_idx;
    logic [SYM_W-1:0]  pat_q;
    logic [LEN_W-1:0]  pref_q;
    logic              wr_en;
    logic              fall;
    logic              in_range;
    logic              sym_hit;
    logic [LEN_W-1:0]  k_fin;
    logic [LEN_W-1:0]  commit_k;
    logic              commit;
    logic              slot_free;
    logic              hit;

    assign pref_idx = rd_idx - LEN_W'(1);

    kmp_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_PATTERN)
    ) u_pattern_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (len_reg[ADDR_W-1:0]),
        .wr_data (sym_reg),
        .rd_addr (rd_idx[ADDR_W-1:0]),
        .rd_data (pat_q)
    );

    kmp_ram #(
        .WIDTH (LEN_W),
        .DEPTH (MAX_PATTERN)
    ) u_prefix_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (len_reg[ADDR_W-1:0]),
        .wr_data (k_fin),
        .rd_addr (pref_idx[ADDR_W-1:0]),
        .rd_data (pref_q)
    );

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // ram data in WALK belongs to k_reg: pattern[k] and prefix[k-1]
    assign in_range  = (k_reg < len_reg);
    assign sym_hit   = (pat_q == sym_reg);
    assign fall      = (k_reg != '0) && (!in_range || !sym_hit);
    assign k_fin     = (in_range && sym_hit) ? (k_reg + LEN_W'(1)) : k_reg;
    assign slot_free = !out_valid_reg || !result_stall;
    assign commit_k  = (state_reg == ST_WALK) ? k_fin : k_reg;
    assign hit       = (len_reg != '0) && (commit_k == len_reg);

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        sym_next       = sym_reg;
        text_next      = text_reg;
        len_next       = len_reg;
        match_len_next = match_len_reg;
        pos_next       = pos_reg;
        wr_en          = 1'b0;
        commit         = 1'b0;
        rd_idx         = k_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    sym_next = item.symbol;
                    case (item.action)
                        ACT_CLEAR:
                        begin
                            len_next       = '0;
                            match_len_next = '0;
                            pos_next       = '0;
                        end
                        ACT_APPEND:
                        begin
                            if (len_reg < LEN_W'(MAX_PATTERN))
                            begin
                                text_next = 1'b0;
                                k_next    = '0;
                                // a non-empty pattern starts from prefix[len-1]
                                state_next = (len_reg == '0) ? ST_WALK : ST_LOAD;
                            end
                        end
                        ACT_TEXT:
                        begin
                            text_next  = 1'b1;
                            k_next     = match_len_reg;
                            state_next = ST_WALK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
                if (item_valid && (item.action == ACT_APPEND) && (len_reg != '0))
                begin
                    rd_idx = len_reg;
                end
                else
                begin
                    rd_idx = k_next;
                end
            end
            ST_LOAD:
            begin
                k_next     = pref_q;
                state_next = ST_WALK;
                rd_idx     = k_next;
            end
            ST_WALK:
            begin
                if (fall)
                begin
                    k_next = pref_q;
                end
                else if (!text_reg)
                begin
                    wr_en          = 1'b1;
                    len_next       = len_reg + LEN_W'(1);
                    match_len_next = '0;
                    pos_next       = '0;
                    state_next     = ST_IDLE;
                end
                else if (slot_free)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next     = k_fin;
                    state_next = ST_RESULT;
                end
                rd_idx = k_next;
            end
            ST_RESULT:
            begin
                if (slot_free)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (commit)
        begin
            match_len_next = commit_k;
            pos_next       = pos_reg + POSITION_BITS'(1);
        end

        out_valid_next = commit || (out_valid_reg && result_stall);
        out_next       = out_reg;
        if (commit)
        begin
            out_next.match          = hit;
            out_next.start_position = hit
                ? (pos_reg - POSITION_BITS'(len_reg) + POSITION_BITS'(1))
                : '0;
            out_next.matched_length = commit_k;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            match_len_reg <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            match_len_reg <= match_len_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        sym_reg  <= sym_next;
        text_reg <= text_next;
        out_reg  <= out_next;
    end

    // matched length never runs past the stored pattern
    a_match_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        match_len_reg <= len_reg)
        else $error("match length exceeds pattern length");

    // an append write only lands inside the rams
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (len_reg < LEN_W'(MAX_PATTERN)))
        else $error("pattern write beyond capacity");

    // the walk index stays within the pattern
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (k_reg <= len_reg))
        else $error("walk index beyond pattern length");

    // a finished text byte always yields a pending result on the next cycle
    a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> result_valid)
        else $error("text transfer finished without a result");

endmodule
